@@ rtl/cht_pkg.sv @@
// Shared types, constants and hash helpers for the two-table cuckoo hash map.
// Used by cht_front, cht_engine and the top level; depends on nothing else.
package cht_pkg;

    localparam int TABLE_SIZE = 256;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int KEY_W      = 32;
    localparam int VAL_W      = 32;
    localparam int CNT_W      = 10;
    localparam int KICK_W     = 9;
    localparam int OP_W       = 2;
    localparam int ST_W       = 2;
    localparam int ENTRY_W    = KEY_W + VAL_W;
    // table word: valid bit on top of key and value
    localparam int WORD_W     = ENTRY_W + 1;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);

    localparam logic [KICK_W-1:0] KICKS_RESET = KICK_W'(256);

    // 2^35/7 rounded up is 2^32 + RECIP_LO; exact floor(x/7) for any 32-bit x
    localparam logic [31:0] RECIP_LO = 32'h2492_4925;
    localparam int          RECIP_SH = 35;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [ST_W-1:0] ST_DONE      = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
        logic [IDX_W-1:0] p1;
        logic [IDX_W-1:0] p2;
    } t_item;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] found;
        logic [ST_W-1:0]  status;
        logic [KEY_W-1:0] spill_key;
        logic [VAL_W-1:0] spill_val;
        logic [CNT_W-1:0] count;
    } t_result;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LOOK, S_K1_RD, S_K1, S_H1, S_H2, S_K2_RD, S_K2
    } t_state;

    function automatic logic [KEY_W-1:0] cht_mag(input logic [KEY_W-1:0] k);
        return k[KEY_W-1] ? (~k + KEY_W'(1)) : k;
    endfunction

    function automatic logic [63:0] cht_mul7(input logic [KEY_W-1:0] m);
        return 64'(m) * 64'(RECIP_LO);
    endfunction

    // second slot from magnitude and its registered partial product
    function automatic logic [IDX_W-1:0] cht_slot2(input logic [KEY_W-1:0] m,
                                                   input logic [63:0] prod);
        logic [65:0] sum;
        sum = {2'b00, m, 32'b0} + {2'b00, prod};
        return sum[RECIP_SH +: IDX_W];
    endfunction

endpackage

@@ rtl/cht_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cht_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/cht_front.sv @@
// Front end: accepts request beats, hashes the key to both slots and queues them.
// Depends on cht_pkg.
module cht_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [cht_pkg::OP_W-1:0]  i_op,
    input  logic [cht_pkg::KEY_W-1:0] i_key,
    input  logic [cht_pkg::VAL_W-1:0] i_val,
    output logic                  o_q_valid,
    output cht_pkg::t_item        o_q_item,
    input  logic                  i_q_pop
);
    import cht_pkg::*;

    logic             r_s1_vld;
    logic [OP_W-1:0]  r_s1_op;
    logic [KEY_W-1:0] r_s1_key, r_s1_mag;
    logic [VAL_W-1:0] r_s1_val;
    logic [63:0]      r_s1_prod;

    t_item             r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_cnt;
    logic              push, take;
    logic [KEY_W-1:0]  in_mag;

    assign push    = r_s1_vld && (r_cnt < (QPTR_W+1)'(QDEPTH));
    assign o_ready = !r_s1_vld || push;
    assign take    = i_valid && o_ready;
    assign in_mag  = cht_mag(i_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (take) begin
            r_s1_vld <= 1'b1;
        end else if (push) begin
            r_s1_vld <= 1'b0;
        end
        if (take) begin
            r_s1_op   <= i_op;
            r_s1_key  <= i_key;
            r_s1_val  <= i_val;
            r_s1_mag  <= in_mag;
            r_s1_prod <= cht_mul7(in_mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (i_q_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            r_cnt <= r_cnt + (QPTR_W+1)'(push) - (QPTR_W+1)'(i_q_pop);
        end
        if (push) begin
            r_q[r_wp] <= '{op: r_s1_op, key: r_s1_key, val: r_s1_val,
                           p1: r_s1_mag[IDX_W-1:0],
                           p2: cht_slot2(r_s1_mag, r_s1_prod)};
        end
    end

    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_q[r_rp];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QPTR_W+1)'(QDEPTH)) else $error("queue overflow");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> r_cnt != '0) else $error("pop from empty queue");
    a_push_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !push |=> r_s1_vld && $stable(r_s1_key))
        else $error("stage lost an item");
endmodule

@@ rtl/cht_engine.sv @@
// Back end: clears both tables, runs lookup, insert with displacement, remove.
// Depends on cht_pkg and cht_ram.
module cht_engine (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_valid,
    input  cht_pkg::t_item           i_q_item,
    output logic                     o_q_pop,
    input  logic [cht_pkg::KICK_W-1:0] i_max_kicks,
    output logic                     o_valid,
    input  logic                     i_ready,
    output cht_pkg::t_result         o_res
);
    import cht_pkg::*;

    t_state r_state, n_state;
    t_item  r_it, n_it;
    logic [KEY_W-1:0]  r_ck, n_ck, r_mag, n_mag;
    logic [VAL_W-1:0]  r_cv, n_cv;
    logic [63:0]       r_prod, n_prod;
    logic [IDX_W-1:0]  r_pos, n_pos;
    logic [KICK_W-1:0] r_round, n_round;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;

    logic                we1, we2;
    logic [IDX_W-1:0]    wa1, wa2, ra1, ra2;
    logic [WORD_W-1:0]   wd1, wd2, rd1, rd2;
    logic                vld1, vld2;
    logic [KEY_W-1:0]    rk1, rk2, mag_rk2;
    logic [VAL_W-1:0]    rv1, rv2;
    logic                h1, h2, fin;

    cht_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_SIZE)) u_tab1 (
        .i_clk, .i_we(we1), .i_waddr(wa1), .i_wdata(wd1), .i_raddr(ra1), .o_rdata(rd1));
    cht_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_SIZE)) u_tab2 (
        .i_clk, .i_we(we2), .i_waddr(wa2), .i_wdata(wd2), .i_raddr(ra2), .o_rdata(rd2));

    assign {vld1, rk1, rv1} = rd1;
    assign {vld2, rk2, rv2} = rd2;
    assign mag_rk2 = cht_mag(rk2);
    assign h1 = vld1 && (rk1 == r_it.key);
    assign h2 = !h1 && vld2 && (rk2 == r_it.key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_pos       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
            r_pos       <= n_pos;
        end
        r_it    <= n_it;
        r_ck    <= n_ck;
        r_cv    <= n_cv;
        r_mag   <= n_mag;
        r_prod  <= n_prod;
        r_round <= n_round;
        r_out   <= n_out;
    end

    always_comb begin
        n_state = r_state;  n_it = r_it;   n_ck = r_ck;   n_cv = r_cv;
        n_mag = r_mag;      n_prod = r_prod; n_pos = r_pos; n_round = r_round;
        n_count = r_count;  n_out = r_out;
        n_out_valid = r_out_valid && !i_ready;
        o_q_pop = 1'b0;
        we1 = 1'b0; wa1 = r_pos; wd1 = {1'b1, r_ck, r_cv}; ra1 = r_pos;
        we2 = 1'b0; wa2 = r_pos; wd2 = {1'b1, r_ck, r_cv}; ra2 = r_pos;
        fin = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                // walk both tables once, dropping every entry
                we1   = 1'b1;
                we2   = 1'b1;
                wd1   = '0;
                wd2   = '0;
                n_pos = r_pos + IDX_W'(1);
                if (r_pos == IDX_W'(TABLE_SIZE - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                ra1 = i_q_item.p1;
                ra2 = i_q_item.p2;
                if (i_q_valid && !r_out_valid) begin
                    o_q_pop = 1'b1;
                    n_it    = i_q_item;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                fin   = 1'b1;
                n_out = '0;
                n_out.hit = h1 || h2;
                priority case (r_it.op)
                    OP_INSERT: begin
                        wa1 = r_it.p1; wd1 = {1'b1, r_it.key, r_it.val}; we1 = h1;
                        wa2 = r_it.p2; wd2 = {1'b1, r_it.key, r_it.val}; we2 = h2;
                        if (!h1 && !h2) begin
                            if (i_max_kicks == '0) begin
                                n_out.status    = ST_FULL;
                                n_out.spill_key = r_it.key;
                                n_out.spill_val = r_it.val;
                            end else begin
                                fin     = 1'b0;
                                n_ck    = r_it.key;
                                n_cv    = r_it.val;
                                n_pos   = r_it.p1;
                                n_round = '0;
                                n_state = S_K1_RD;
                            end
                        end
                    end
                    OP_REMOVE: begin
                        wa1 = r_it.p1; wd1 = {1'b0, r_it.key, r_it.val}; we1 = h1;
                        wa2 = r_it.p2; wd2 = {1'b0, r_it.key, r_it.val}; we2 = h2;
                        if (h1 || h2) begin
                            n_count = r_count - CNT_W'(1);
                        end else begin
                            n_out.status = ST_NOT_FOUND;
                        end
                    end
                    default: begin
                        n_out.found = h1 ? rv1 : (h2 ? rv2 : '0);
                    end
                endcase
            end
            S_K1_RD: n_state = S_K1;
            S_K1: begin
                we1 = 1'b1;
                if (!vld1) begin
                    n_count     = r_count + CNT_W'(1);
                    fin         = 1'b1;
                    n_out       = '0;
                end else begin
                    // evict the resident, which heads for its second slot
                    n_ck    = rk1;
                    n_cv    = rv1;
                    n_mag   = cht_mag(rk1);
                    n_state = S_H1;
                end
            end
            S_H1: begin
                n_prod  = cht_mul7(r_mag);
                n_state = S_H2;
            end
            S_H2: begin
                n_pos   = cht_slot2(r_mag, r_prod);
                n_state = S_K2_RD;
            end
            S_K2_RD: n_state = S_K2;
            S_K2: begin
                we2 = 1'b1;
                if (!vld2) begin
                    n_count     = r_count + CNT_W'(1);
                    fin         = 1'b1;
                    n_out       = '0;
                end else begin
                    n_ck = rk2;
                    n_cv = rv2;
                    if (r_round + KICK_W'(1) == i_max_kicks) begin
                        fin             = 1'b1;
                        n_out           = '0;
                        n_out.status    = ST_FULL;
                        n_out.spill_key = rk2;
                        n_out.spill_val = rv2;
                    end else begin
                        n_round = r_round + KICK_W'(1);
                        n_pos   = mag_rk2[IDX_W-1:0];
                        n_state = S_K1_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (fin) begin
            n_out.count = n_count;
            n_out_valid = 1'b1;
            n_state     = S_IDLE;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> r_state == S_IDLE && !r_out_valid) else $error("pop while busy");
    a_full_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status == ST_FULL |-> !r_out.hit)
        else $error("full insert flagged as hit");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(2 * TABLE_SIZE)) else $error("entry count out of range");
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_CLEAR |-> !(we1 && we2)) else $error("both tables written at once");
endmodule

@@ rtl/cuckoo_hash_table.sv @@
// Two-table cuckoo hash map, top level: front end, request queue, table engine.
// Depends on cht_pkg, cht_front, cht_engine (and cht_ram through the engine).
//
// Usage:
//   Requests enter on the s_axis group: tuser carries the operation
//   (lookup, insert/update, remove), tdata the key and value. Each request
//   yields exactly one result beat on m_axis: tuser carries hit and status,
//   tdata the found value, the spilled entry and the entry count.
//   The cfg channel writes max_kicks, the displacement round limit; it is
//   always ready and must be written only while the block is idle.
//   A request is registered in the hashing stage, then queued; the engine
//   pops it, reads both tables and answers a lookup, remove or update from
//   that read. A new insert then reads its first slot and settles there if
//   it is empty; else each displacement round waits on the table read ports
//   and the registered divide-by-seven hash of each evicted key.
//   Flow: one request in flight in the engine, the next taken only after
//   the result beat leaves; up to three more are buffered ahead of it, so
//   s_axis keeps accepting until those buffers are full.
//   Reset clears the count and starts a pass that empties both tables;
//   requests queue up meanwhile. max_kicks returns to 256.
//   A stalled m_axis holds its beat and the engine waits.
module cuckoo_hash_table (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [1:0]   s_axis_tuser,   // operation
    input  logic [63:0]  s_axis_tdata,   // key, value
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [2:0]   m_axis_tuser,   // hit, status
    output logic [111:0] m_axis_tdata,   // found_value, spill_key, spill_value, entry_count, pad
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [8:0]   i_cfg_data      // max_kicks
);
    import cht_pkg::*;

    logic              q_valid, q_pop;
    t_item             q_item;
    t_result           res;
    logic [KICK_W-1:0] r_max_kicks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_kicks <= KICKS_RESET;
        end else if (i_cfg_valid) begin
            r_max_kicks <= i_cfg_data;
        end
    end
    assign o_cfg_ready = 1'b1;

    cht_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_op(s_axis_tuser), .i_key(s_axis_tdata[31:0]), .i_val(s_axis_tdata[63:32]),
        .o_q_valid(q_valid), .o_q_item(q_item), .i_q_pop(q_pop));

    cht_engine u_engine (
        .i_clk, .i_rst_n,
        .i_q_valid(q_valid), .i_q_item(q_item), .o_q_pop(q_pop),
        .i_max_kicks(r_max_kicks),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res));

    assign m_axis_tuser = {res.status, res.hit};
    assign m_axis_tdata = {6'b0, res.count, res.spill_val, res.spill_key, res.found};
endmodule
